// ===== hdl/rvid_pkg.sv =====
// Shared types and encodings for the RV32 instruction decoder.
package rvid_pkg;

	// Major opcodes, instruction bits 6..0.
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_AMO    = 7'h2f;

	// Funct7 codes and the atomic funct5 code.
	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [4:0] F5_AMOSWAP = 5'h01;

	// Funct3 codes.
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;
	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_BYTEU = 3'd4;

	typedef enum logic [4:0] {
		OP_JAL     = 5'd0,
		OP_LUI     = 5'd1,
		OP_AUIPC   = 5'd2,
		OP_JALR    = 5'd3,
		OP_ADDI    = 5'd4,
		OP_XORI    = 5'd5,
		OP_ANDI    = 5'd6,
		OP_SLLI    = 5'd7,
		OP_SRLI    = 5'd8,
		OP_LW      = 5'd9,
		OP_LBU     = 5'd10,
		OP_SB      = 5'd11,
		OP_SW      = 5'd12,
		OP_BEQ     = 5'd13,
		OP_BNE     = 5'd14,
		OP_BLT     = 5'd15,
		OP_BGE     = 5'd16,
		OP_BLTU    = 5'd17,
		OP_BGEU    = 5'd18,
		OP_ADD     = 5'd19,
		OP_SUB     = 5'd20,
		OP_SLTU    = 5'd21,
		OP_OR      = 5'd22,
		OP_AND     = 5'd23,
		OP_MUL     = 5'd24,
		OP_DIVU    = 5'd25,
		OP_ECALL   = 5'd26,
		OP_AMOSWAP = 5'd27
	} op_t;

	typedef enum logic [2:0] {
		FMT_R = 3'd0,
		FMT_I = 3'd1,
		FMT_S = 3'd2,
		FMT_B = 3'd3,
		FMT_U = 3'd4,
		FMT_J = 3'd5
	} fmt_t;

	// One decoded item.
	typedef struct packed {
		logic        illegal;
		op_t         op;
		fmt_t        fmt;
		logic [4:0]  rd;
		logic [4:0]  rs1;
		logic [4:0]  rs2;
		logic [31:0] imm;
	} dec_t;

endpackage

// ===== hdl/rv32_instruction_decoder_unit.sv =====
// Top level of the RV32 instruction decoder: input register, decode logic, result register.
// The decode is a single pass of logic between the input register and the result register.
// Throughput: one item per cycle while the output is not stalled.
// A stalled result holds the result register; an empty input register still takes one more item.
// Reset clears both stage valid flags asynchronously; the payload registers are not reset.
module rv32_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        illegal,
	output logic [4:0]  op_code,
	output logic [2:0]  format,
	output logic [4:0]  dest_reg,
	output logic [4:0]  src1_reg,
	output logic [4:0]  src2_reg,
	output logic [31:0] immediate
);

	logic            valid_s1;
	logic            valid_s2;
	logic [31:0]     instr_s1;
	rvid_pkg::dec_t  dec_s2;
	rvid_pkg::dec_t  dec;
	logic            adv_s1;
	logic            adv_s2;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instr_word;
		end
		if (adv_s2 && valid_s1) begin
			dec_s2 <= dec;
		end
	end

	assign opc   = instr_s1[6:0];
	assign f3    = instr_s1[14:12];
	assign f7    = instr_s1[31:25];
	assign imm_i = {{20{instr_s1[31]}}, instr_s1[31:20]};

	always_comb begin
		dec         = '0;
		dec.illegal = 1'b0;
		dec.op      = rvid_pkg::OP_JAL;
		dec.fmt     = rvid_pkg::FMT_R;
		unique case (opc)
			rvid_pkg::OPC_JAL: begin
				dec.fmt = rvid_pkg::FMT_J;
				dec.rd  = instr_s1[11:7];
				dec.imm = {{12{instr_s1[31]}}, instr_s1[19:12], instr_s1[20],
					instr_s1[30:21], 1'b0};
			end
			rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
				dec.op  = (opc == rvid_pkg::OPC_LUI) ? rvid_pkg::OP_LUI : rvid_pkg::OP_AUIPC;
				dec.fmt = rvid_pkg::FMT_U;
				dec.rd  = instr_s1[11:7];
				dec.imm = {12'd0, instr_s1[31:12]};
			end
			rvid_pkg::OPC_JALR: begin
				dec.op  = rvid_pkg::OP_JALR;
				dec.fmt = rvid_pkg::FMT_I;
				dec.rd  = instr_s1[11:7];
				dec.rs1 = instr_s1[19:15];
				dec.imm = imm_i;
			end
			rvid_pkg::OPC_OP_IMM: begin
				dec.fmt = rvid_pkg::FMT_I;
				dec.rd  = instr_s1[11:7];
				dec.rs1 = instr_s1[19:15];
				dec.imm = imm_i;
				priority if (f3 == rvid_pkg::F3_ADD) begin
					dec.op = rvid_pkg::OP_ADDI;
				end else if (f3 == rvid_pkg::F3_XOR) begin
					dec.op = rvid_pkg::OP_XORI;
				end else if (f3 == rvid_pkg::F3_AND) begin
					dec.op = rvid_pkg::OP_ANDI;
				end else if ((f3 == rvid_pkg::F3_SLL || f3 == rvid_pkg::F3_SRL)
						&& f7 == rvid_pkg::F7_BASE) begin
					// Shifts carry only the 5-bit amount, not sign-extended.
					dec.op  = (f3 == rvid_pkg::F3_SLL) ? rvid_pkg::OP_SLLI
						: rvid_pkg::OP_SRLI;
					dec.imm = {27'd0, instr_s1[24:20]};
				end else begin
					dec.illegal = 1'b1;
				end
			end
			rvid_pkg::OPC_LOAD: begin
				dec.fmt = rvid_pkg::FMT_I;
				dec.rd  = instr_s1[11:7];
				dec.rs1 = instr_s1[19:15];
				dec.imm = imm_i;
				unique case (f3)
					rvid_pkg::F3_WORD:  dec.op = rvid_pkg::OP_LW;
					rvid_pkg::F3_BYTEU: dec.op = rvid_pkg::OP_LBU;
					default:            dec.illegal = 1'b1;
				endcase
			end
			rvid_pkg::OPC_STORE: begin
				dec.fmt = rvid_pkg::FMT_S;
				dec.rs1 = instr_s1[19:15];
				dec.rs2 = instr_s1[24:20];
				dec.imm = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
				unique case (f3)
					rvid_pkg::F3_BYTE: dec.op = rvid_pkg::OP_SB;
					rvid_pkg::F3_WORD: dec.op = rvid_pkg::OP_SW;
					default:           dec.illegal = 1'b1;
				endcase
			end
			rvid_pkg::OPC_BRANCH: begin
				dec.fmt = rvid_pkg::FMT_B;
				dec.rs1 = instr_s1[19:15];
				dec.rs2 = instr_s1[24:20];
				dec.imm = {{20{instr_s1[31]}}, instr_s1[7], instr_s1[30:25],
					instr_s1[11:8], 1'b0};
				unique case (f3)
					rvid_pkg::F3_BEQ:  dec.op = rvid_pkg::OP_BEQ;
					rvid_pkg::F3_BNE:  dec.op = rvid_pkg::OP_BNE;
					rvid_pkg::F3_BLT:  dec.op = rvid_pkg::OP_BLT;
					rvid_pkg::F3_BGE:  dec.op = rvid_pkg::OP_BGE;
					rvid_pkg::F3_BLTU: dec.op = rvid_pkg::OP_BLTU;
					rvid_pkg::F3_BGEU: dec.op = rvid_pkg::OP_BGEU;
					default:           dec.illegal = 1'b1;
				endcase
			end
			rvid_pkg::OPC_OP: begin
				dec.fmt = rvid_pkg::FMT_R;
				dec.rd  = instr_s1[11:7];
				dec.rs1 = instr_s1[19:15];
				dec.rs2 = instr_s1[24:20];
				priority if (f3 == rvid_pkg::F3_ADD && f7 == rvid_pkg::F7_BASE) begin
					dec.op = rvid_pkg::OP_ADD;
				end else if (f3 == rvid_pkg::F3_ADD && f7 == rvid_pkg::F7_ALT) begin
					dec.op = rvid_pkg::OP_SUB;
				end else if (f3 == rvid_pkg::F3_SLTU && f7 == rvid_pkg::F7_BASE) begin
					dec.op = rvid_pkg::OP_SLTU;
				end else if (f3 == rvid_pkg::F3_OR && f7 == rvid_pkg::F7_BASE) begin
					dec.op = rvid_pkg::OP_OR;
				end else if (f3 == rvid_pkg::F3_AND && f7 == rvid_pkg::F7_BASE) begin
					dec.op = rvid_pkg::OP_AND;
				end else if (f3 == rvid_pkg::F3_ADD && f7 == rvid_pkg::F7_MULDIV) begin
					dec.op = rvid_pkg::OP_MUL;
				end else if (f3 == rvid_pkg::F3_SRL && f7 == rvid_pkg::F7_MULDIV) begin
					dec.op = rvid_pkg::OP_DIVU;
				end else begin
					dec.illegal = 1'b1;
				end
			end
			rvid_pkg::OPC_SYSTEM: begin
				// The rd, rs1 and funct3 bits of a system call are ignored.
				dec.fmt = rvid_pkg::FMT_I;
				if (instr_s1[31:20] == 12'd0) begin
					dec.op = rvid_pkg::OP_ECALL;
				end else begin
					dec.illegal = 1'b1;
				end
			end
			rvid_pkg::OPC_AMO: begin
				// The acquire and release bits are ignored.
				if (f3 == rvid_pkg::F3_WORD && instr_s1[31:27] == rvid_pkg::F5_AMOSWAP) begin
					dec.op  = rvid_pkg::OP_AMOSWAP;
					dec.fmt = rvid_pkg::FMT_R;
					dec.rd  = instr_s1[11:7];
					dec.rs1 = instr_s1[19:15];
					dec.rs2 = instr_s1[24:20];
				end else begin
					dec.illegal = 1'b1;
				end
			end
			default: begin
				dec.illegal = 1'b1;
			end
		endcase
		if (dec.illegal) begin
			dec         = '0;
			dec.illegal = 1'b1;
		end
	end

	assign out_valid = valid_s2;
	assign illegal   = dec_s2.illegal;
	assign op_code   = dec_s2.op;
	assign format    = dec_s2.fmt;
	assign dest_reg  = dec_s2.rd;
	assign src1_reg  = dec_s2.rs1;
	assign src2_reg  = dec_s2.rs2;
	assign immediate = dec_s2.imm;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && illegal |-> op_code == rvid_pkg::OP_JAL && format == rvid_pkg::FMT_R
			&& dest_reg == 5'd0 && src1_reg == 5'd0 && src2_reg == 5'd0
			&& immediate == 32'd0)
		else $error("illegal item carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (format == rvid_pkg::FMT_S || format == rvid_pkg::FMT_B)
			|-> dest_reg == 5'd0)
		else $error("store or branch item carries a destination register");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (format == rvid_pkg::FMT_U || format == rvid_pkg::FMT_J)
			|-> src1_reg == 5'd0 && src2_reg == 5'd0)
		else $error("upper or jump item carries a source register");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled while a stage is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(instr_s1))
		else $error("held instruction word lost while the result register is stalled");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the RV32 instruction decoder unit.
`timescale 1ns / 1ps

module tb;
	import rvid_pkg::*;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int IDLE_PERCENT   = 24;
	localparam int WATCHDOG_LIMIT = 500;
	localparam int DRAIN_CYCLES   = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instr_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        illegal;
	logic [4:0]  op_code;
	logic [2:0]  format;
	logic [4:0]  dest_reg;
	logic [4:0]  src1_reg;
	logic [4:0]  src2_reg;
	logic [31:0] immediate;

	logic [31:0] instr_queue[$];
	dec_t        pending_decodes[$];
	int          mismatches = 0;
	int          cycle_cnt = 0;
	int          idle_cycles = 0;

	rv32_instruction_decoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.instr_word (instr_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.illegal    (illegal),
		.op_code    (op_code),
		.format     (format),
		.dest_reg   (dest_reg),
		.src1_reg   (src1_reg),
		.src2_reg   (src2_reg),
		.immediate  (immediate)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Both sides run flat out during this window so back-to-back traffic is seen.
	function automatic logic quiet_window();
		return cycle_cnt >= 700 && cycle_cnt < 1200;
	endfunction

	function automatic dec_t decode_word(input logic [31:0] w);
		dec_t       d;
		logic [6:0] opc;
		logic [6:0] f7;
		logic [2:0] f3;
		logic       ok;
		opc = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		d = '0;
		ok = 1'b1;
		case (opc)
			OPC_JAL: begin
				d.op = OP_JAL;
				d.fmt = FMT_J;
				d.rd = w[11:7];
				d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_LUI, OPC_AUIPC: begin
				d.op = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
				d.fmt = FMT_U;
				d.rd = w[11:7];
				d.imm = {12'b0, w[31:12]};
			end
			OPC_JALR: begin
				d.op = OP_JALR;
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.imm = {{20{w[31]}}, w[31:20]};
			end
			OPC_OP_IMM: begin
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.imm = {{20{w[31]}}, w[31:20]};
				case (f3)
					F3_ADD: d.op = OP_ADDI;
					F3_XOR: d.op = OP_XORI;
					F3_AND: d.op = OP_ANDI;
					F3_SLL, F3_SRL: begin
						// Shifts carry only the 5-bit amount, and the upper bits must be clear.
						if (f7 == F7_BASE) begin
							d.op = (f3 == F3_SLL) ? OP_SLLI : OP_SRLI;
							d.imm = {27'b0, w[24:20]};
						end else begin
							ok = 1'b0;
						end
					end
					default: ok = 1'b0;
				endcase
			end
			OPC_LOAD: begin
				d.fmt = FMT_I;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.imm = {{20{w[31]}}, w[31:20]};
				case (f3)
					F3_WORD:  d.op = OP_LW;
					F3_BYTEU: d.op = OP_LBU;
					default:  ok = 1'b0;
				endcase
			end
			OPC_STORE: begin
				d.fmt = FMT_S;
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
				case (f3)
					F3_BYTE: d.op = OP_SB;
					F3_WORD: d.op = OP_SW;
					default: ok = 1'b0;
				endcase
			end
			OPC_BRANCH: begin
				d.fmt = FMT_B;
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				case (f3)
					F3_BEQ:  d.op = OP_BEQ;
					F3_BNE:  d.op = OP_BNE;
					F3_BLT:  d.op = OP_BLT;
					F3_BGE:  d.op = OP_BGE;
					F3_BLTU: d.op = OP_BLTU;
					F3_BGEU: d.op = OP_BGEU;
					default: ok = 1'b0;
				endcase
			end
			OPC_OP: begin
				d.fmt = FMT_R;
				d.rd = w[11:7];
				d.rs1 = w[19:15];
				d.rs2 = w[24:20];
				case ({f7, f3})
					{F7_BASE, F3_ADD}:   d.op = OP_ADD;
					{F7_ALT, F3_ADD}:    d.op = OP_SUB;
					{F7_BASE, F3_SLTU}:  d.op = OP_SLTU;
					{F7_BASE, F3_OR}:    d.op = OP_OR;
					{F7_BASE, F3_AND}:   d.op = OP_AND;
					{F7_MULDIV, F3_ADD}: d.op = OP_MUL;
					{F7_MULDIV, F3_SRL}: d.op = OP_DIVU;
					default:             ok = 1'b0;
				endcase
			end
			OPC_SYSTEM: begin
				// The rd, rs1 and funct3 bits of an environment call are don't-cares.
				d.fmt = FMT_I;
				if (w[31:20] == 12'h000)
					d.op = OP_ECALL;
				else
					ok = 1'b0;
			end
			OPC_AMO: begin
				if (f3 == F3_WORD && w[31:27] == F5_AMOSWAP) begin
					d.op = OP_AMOSWAP;
					d.fmt = FMT_R;
					d.rd = w[11:7];
					d.rs1 = w[19:15];
					d.rs2 = w[24:20];
				end else begin
					ok = 1'b0;
				end
			end
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			d = '0;
			d.illegal = 1'b1;
		end
		return d;
	endfunction

	// Mostly legal encodings with random operands; some keep a valid opcode with
	// random funct bits, and a few are pure noise.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int unsigned pick;
		int unsigned sel;
		logic        shaped;
		w = $urandom();
		pick = $urandom_range(99);
		if (pick < 8)
			return w;
		shaped = pick >= 20;
		case ($urandom_range(10))
			0: w[6:0] = OPC_JAL;
			1: w[6:0] = $urandom_range(1) ? OPC_LUI : OPC_AUIPC;
			2: w[6:0] = OPC_JALR;
			3: begin
				w[6:0] = OPC_OP_IMM;
				if (shaped) begin
					sel = $urandom_range(4);
					case (sel)
						0: w[14:12] = F3_ADD;
						1: w[14:12] = F3_XOR;
						2: w[14:12] = F3_AND;
						3: w[14:12] = F3_SLL;
						default: w[14:12] = F3_SRL;
					endcase
					if (sel >= 3)
						w[31:25] = F7_BASE;
				end
			end
			4: begin
				w[6:0] = OPC_LOAD;
				if (shaped)
					w[14:12] = $urandom_range(1) ? F3_WORD : F3_BYTEU;
			end
			5: begin
				w[6:0] = OPC_STORE;
				if (shaped)
					w[14:12] = $urandom_range(1) ? F3_WORD : F3_BYTE;
			end
			6: begin
				w[6:0] = OPC_BRANCH;
				if (shaped) begin
					sel = $urandom_range(5);
					w[14:12] = (sel < 2) ? 3'(sel) : 3'(sel + 2);
				end
			end
			7, 8: begin
				w[6:0] = OPC_OP;
				if (shaped) begin
					case ($urandom_range(6))
						0: {w[31:25], w[14:12]} = {F7_BASE, F3_ADD};
						1: {w[31:25], w[14:12]} = {F7_ALT, F3_ADD};
						2: {w[31:25], w[14:12]} = {F7_BASE, F3_SLTU};
						3: {w[31:25], w[14:12]} = {F7_BASE, F3_OR};
						4: {w[31:25], w[14:12]} = {F7_BASE, F3_AND};
						5: {w[31:25], w[14:12]} = {F7_MULDIV, F3_ADD};
						default: {w[31:25], w[14:12]} = {F7_MULDIV, F3_SRL};
					endcase
				end
			end
			9: begin
				w[6:0] = OPC_SYSTEM;
				if (shaped)
					w[31:20] = 12'h000;
			end
			default: begin
				w[6:0] = OPC_AMO;
				if (shaped) begin
					w[14:12] = F3_WORD;
					w[31:27] = F5_AMOSWAP;
				end
			end
		endcase
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Driver: presents instruction words and records the decode of each accepted item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			instr_word <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				pending_decodes.push_back(decode_word(instr_word));
			if (instr_queue.size() != 0 &&
				(quiet_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
				in_valid <= 1'b1;
				instr_word <= instr_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: stalls the output at random and checks every accepted item.
	always @(posedge clk or negedge arst_n) begin
		dec_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_decodes.size() == 0) begin
					$display("%0t: unexpected item, expected none, got op_code %h",
						$time, op_code);
					mismatches++;
				end else begin
					want = pending_decodes.pop_front();
					check_field("illegal", 32'(want.illegal), 32'(illegal));
					check_field("op_code", 32'(want.op), 32'(op_code));
					check_field("format", 32'(want.fmt), 32'(format));
					check_field("dest_reg", 32'(want.rd), 32'(dest_reg));
					check_field("src1_reg", 32'(want.rs1), 32'(src1_reg));
					check_field("src2_reg", 32'(want.rs2), 32'(src2_reg));
					check_field("immediate", want.imm, immediate);
				end
			end
			out_stall <= !quiet_window() && $urandom_range(99) < IDLE_PERCENT;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
			idle_cycles <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout at %0t after %0d cycles without progress", $time, idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [2:0] branch_f3[6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
		logic [9:0] alu_sel[7] = '{{F7_BASE, F3_ADD}, {F7_ALT, F3_ADD}, {F7_BASE, F3_SLTU},
			{F7_BASE, F3_OR}, {F7_BASE, F3_AND}, {F7_MULDIV, F3_ADD}, {F7_MULDIV, F3_SRL}};

		instr_queue.push_back(32'h0000_0000);
		instr_queue.push_back(32'hffff_ffff);
		instr_queue.push_back({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL});
		instr_queue.push_back({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd31, OPC_JAL});
		instr_queue.push_back({20'hfffff, 5'd31, OPC_LUI});
		instr_queue.push_back({20'h80000, 5'd1, OPC_AUIPC});
		// Jump-and-link-register decodes whatever its funct3 holds.
		instr_queue.push_back({12'h800, 5'd31, 3'd7, 5'd5, OPC_JALR});
		instr_queue.push_back({12'hfff, 5'd2, F3_ADD, 5'd3, OPC_OP_IMM});
		instr_queue.push_back({12'h7ff, 5'd4, F3_XOR, 5'd5, OPC_OP_IMM});
		instr_queue.push_back({12'h800, 5'd6, F3_AND, 5'd7, OPC_OP_IMM});
		instr_queue.push_back({F7_BASE, 5'd31, 5'd6, F3_SLL, 5'd7, OPC_OP_IMM});
		instr_queue.push_back({F7_BASE, 5'd0, 5'd31, F3_SRL, 5'd0, OPC_OP_IMM});
		instr_queue.push_back({F7_ALT, 5'd3, 5'd8, F3_SRL, 5'd9, OPC_OP_IMM});
		instr_queue.push_back({12'h800, 5'd10, F3_WORD, 5'd11, OPC_LOAD});
		instr_queue.push_back({12'h7ff, 5'd12, F3_BYTEU, 5'd13, OPC_LOAD});
		instr_queue.push_back({12'h123, 5'd1, F3_BYTE, 5'd2, OPC_LOAD});
		instr_queue.push_back({7'h40, 5'd31, 5'd30, F3_BYTE, 5'd0, OPC_STORE});
		instr_queue.push_back({7'h3f, 5'd1, 5'd2, F3_WORD, 5'h1f, OPC_STORE});
		// Branch offsets alternate between the largest forward and backward reach.
		for (int k = 0; k < 6; k++)
			instr_queue.push_back({k[0], {6{~k[0]}}, 5'(k), 5'(31 - k), branch_f3[k],
				{4{~k[0]}}, ~k[0], OPC_BRANCH});
		for (int k = 0; k < 7; k++)
			instr_queue.push_back({alu_sel[k][9:3], 5'(31 - k), 5'(k), alu_sel[k][2:0],
				5'(k + 20), OPC_OP});
		// Environment call with every ignored field set.
		instr_queue.push_back({12'h000, 5'd31, 3'd7, 5'd31, OPC_SYSTEM});
		instr_queue.push_back({F5_AMOSWAP, 2'b11, 5'd3, 5'd2, F3_WORD, 5'd1, OPC_AMO});
		for (int i = 0; i < RANDOM_ITEMS; i++)
			instr_queue.push_back(random_word());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk); while (instr_queue.size() != 0 || in_valid);
		do @(negedge clk); while (pending_decodes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
